@@ src/exl_pkg.sv @@
package exl_pkg;

  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] CharNine       = 8'h39;
  localparam logic [7:0] CharUnderscore = 8'h5f;
  localparam logic [7:0] CharEqual      = 8'h3d;
  localparam logic [7:0] CharBang       = 8'h21;
  localparam logic [7:0] CharLess       = 8'h3c;
  localparam logic [7:0] CharGreater    = 8'h3e;
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharTab        = 8'h09;
  localparam logic [7:0] CharCr         = 8'h0d;
  localparam logic [7:0] CharLf         = 8'h0a;
  localparam logic [7:0] CharPlus       = 8'h2b;
  localparam logic [7:0] CharMinus      = 8'h2d;
  localparam logic [7:0] CharStar       = 8'h2a;
  localparam logic [7:0] CharSlash      = 8'h2f;
  localparam logic [7:0] CharPercent    = 8'h25;
  localparam logic [7:0] CharLParen     = 8'h28;
  localparam logic [7:0] CharRParen     = 8'h29;
  localparam logic [7:0] CharComma      = 8'h2c;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CandCount  = 4;

  typedef enum logic [4:0] {
    TK_EOF     = 5'd0,
    TK_INT     = 5'd1,
    TK_IDENT   = 5'd2,
    TK_INVALID = 5'd3,
    TK_EQ      = 5'd4,
    TK_NEQ     = 5'd5,
    TK_LTE     = 5'd6,
    TK_GTE     = 5'd7,
    TK_PLUS    = 5'd8,
    TK_MINUS   = 5'd9,
    TK_MUL     = 5'd10,
    TK_DIV     = 5'd11,
    TK_MOD     = 5'd12,
    TK_LT      = 5'd13,
    TK_GT      = 5'd14,
    TK_LPAREN  = 5'd15,
    TK_RPAREN  = 5'd16,
    TK_COMMA   = 5'd17
  } token_kind_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_NUM   = 4'b0010,
    PH_IDENT = 4'b0100,
    PH_HELD  = 4'b1000
  } lex_phase_e;

  typedef enum logic [1:0] {
    HOP_EQUAL   = 2'd0,
    HOP_BANG    = 2'd1,
    HOP_LESS    = 2'd2,
    HOP_GREATER = 2'd3
  } held_op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    token_kind_e        token_kind;
    logic signed [63:0] literal_value;
    logic [31:0]        start_position;
    logic [31:0]        name_length;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                 count;
    out_item_t [MaxResults-1:0] slots;
  } res_bundle_t;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_name_start(input logic [7:0] c);
    return is_letter(c) || (c == CharUnderscore);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharCr) || (c == CharLf);
  endfunction

  function automatic logic is_held_char(input logic [7:0] c);
    return (c == CharEqual) || (c == CharBang) || (c == CharLess) || (c == CharGreater);
  endfunction

  function automatic held_op_e held_code(input logic [7:0] c);
    held_op_e h;
    case (c)
      CharEqual:   h = HOP_EQUAL;
      CharBang:    h = HOP_BANG;
      CharLess:    h = HOP_LESS;
      default:     h = HOP_GREATER;
    endcase
    return h;
  endfunction

  function automatic token_kind_e single_kind(input logic [7:0] c);
    token_kind_e k;
    case (c)
      CharPlus:    k = TK_PLUS;
      CharMinus:   k = TK_MINUS;
      CharStar:    k = TK_MUL;
      CharSlash:   k = TK_DIV;
      CharPercent: k = TK_MOD;
      CharLParen:  k = TK_LPAREN;
      CharRParen:  k = TK_RPAREN;
      CharComma:   k = TK_COMMA;
      default:     k = TK_INVALID;
    endcase
    return k;
  endfunction

  function automatic token_kind_e held_flush_kind(input held_op_e h);
    token_kind_e k;
    case (h)
      HOP_LESS:    k = TK_LT;
      HOP_GREATER: k = TK_GT;
      default:     k = TK_INVALID;
    endcase
    return k;
  endfunction

  function automatic token_kind_e held_pair_kind(input held_op_e h);
    token_kind_e k;
    case (h)
      HOP_EQUAL:   k = TK_EQ;
      HOP_BANG:    k = TK_NEQ;
      HOP_LESS:    k = TK_LTE;
      default:     k = TK_GTE;
    endcase
    return k;
  endfunction

endpackage

@@ src/exl_front.sv @@
module exl_front import exl_pkg::*; #(
  parameter int unsigned PositionBits = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_item_t    item_i,
  output res_bundle_t bundle_o,
  output logic        bundle_valid_o
);

  localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};
  localparam logic [PositionBits-1:0] PosOne = {{(PositionBits-1){1'b0}}, 1'b1};

  lex_phase_e              phase_q, phase_d;
  held_op_e                held_q, held_d;
  logic [63:0]             acc_q, acc_d;
  logic [PositionBits-1:0] start_q, start_d;
  logic [PositionBits-1:0] pos_q, pos_d;

  function automatic logic [31:0] to32(input logic [PositionBits-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic out_item_t mk(input token_kind_e k, input logic [63:0] val,
                                   input logic [PositionBits-1:0] st,
                                   input logic [PositionBits-1:0] len);
    out_item_t r;
    r.token_kind     = k;
    r.literal_value  = val;
    r.start_position = to32(st);
    r.name_length    = to32(len);
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  out_item_t [CandCount-1:0] cand;
  logic      [CandCount-1:0] cand_v;
  logic [7:0]                c;
  logic                      consumed;
  lex_phase_e                phase1;
  held_op_e                  held1;
  logic [63:0]               acc1;
  logic [63:0]               acc_next;
  logic [PositionBits-1:0]   start1;
  logic [PositionBits-1:0]   pos1;
  logic [1:0]                n;
  res_bundle_t               bundle;

  assign c        = item_i.data_byte;
  assign acc_next = (acc_q << 3) + (acc_q << 1) + 64'(c[3:0]);

  always_comb begin
    cand     = '0;
    cand_v   = '0;
    consumed = 1'b0;
    phase1   = phase_q;
    held1    = held_q;
    acc1     = acc_q;
    start1   = start_q;
    pos1     = pos_q;
    if (item_i.byte_present) begin
      case (phase_q)
        PH_NUM: begin
          if (is_numeral(c)) begin
            acc1     = acc_next;
            consumed = 1'b1;
          end else if (is_name_start(c)) begin
            cand[0]   = mk(TK_INVALID, '0, start_q, '0);
            cand_v[0] = 1'b1;
            phase1    = PH_IDLE;
          end else begin
            cand[0]   = mk(TK_INT, acc_q, start_q, '0);
            cand_v[0] = 1'b1;
            phase1    = PH_IDLE;
          end
        end
        PH_IDENT: begin
          if (is_name_start(c) || is_numeral(c)) begin
            consumed = 1'b1;
          end else begin
            cand[0]   = mk(TK_IDENT, '0, start_q, pos_q - start_q);
            cand_v[0] = 1'b1;
            phase1    = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (c == CharEqual) begin
            cand[0]  = mk(held_pair_kind(held_q), '0, start_q, '0);
            consumed = 1'b1;
          end else begin
            cand[0] = mk(held_flush_kind(held_q), '0, start_q, '0);
          end
          cand_v[0] = 1'b1;
          phase1    = PH_IDLE;
        end
        default: begin
        end
      endcase
      if (!consumed && !is_blank(c)) begin
        if (is_numeral(c)) begin
          phase1 = PH_NUM;
          acc1   = 64'(c[3:0]);
          start1 = pos_q;
        end else if (is_name_start(c)) begin
          phase1 = PH_IDENT;
          start1 = pos_q;
        end else if (is_held_char(c)) begin
          phase1 = PH_HELD;
          held1  = held_code(c);
          start1 = pos_q;
        end else begin
          cand[1]   = mk(single_kind(c), '0, pos_q, '0);
          cand_v[1] = 1'b1;
        end
      end
      if (pos_q != PosMax) begin
        pos1 = pos_q + PosOne;
      end
    end

    phase_d = phase1;
    held_d  = held1;
    acc_d   = acc1;
    start_d = start1;
    pos_d   = pos1;
    if (item_i.end_of_source) begin
      case (phase1)
        PH_NUM: begin
          cand[2]   = mk(TK_INT, acc1, start1, '0);
          cand_v[2] = 1'b1;
        end
        PH_IDENT: begin
          cand[2]   = mk(TK_IDENT, '0, start1, pos1 - start1);
          cand_v[2] = 1'b1;
        end
        PH_HELD: begin
          cand[2]   = mk(held_flush_kind(held1), '0, start1, '0);
          cand_v[2] = 1'b1;
        end
        default: begin
        end
      endcase
      cand[3]   = mk(TK_EOF, '0, pos1, '0);
      cand_v[3] = 1'b1;
      phase_d   = PH_IDLE;
      held_d    = HOP_EQUAL;
      acc_d     = '0;
      start_d   = '0;
      pos_d     = '0;
    end
  end

  // pack the candidate results in order, oldest first
  always_comb begin
    bundle = '0;
    n      = '0;
    for (int i = 0; i < CandCount; i++) begin
      if (cand_v[i]) begin
        bundle.slots[n] = cand[i];
        n               = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      bundle.slots[n - 2'd1].last_of_run = 1'b1;
    end
    bundle.count = n;
  end

  assign bundle_o       = bundle;
  assign bundle_valid_o = (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= HOP_EQUAL;
      acc_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      acc_q   <= acc_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

endmodule

@@ src/exl_queue.sv @@
module exl_queue import exl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  res_bundle_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output res_bundle_t data_o
);

  res_bundle_t [1:0] mem_q;
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ src/exl_back.sv @@
module exl_back import exl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  res_bundle_t head_i,
  input  logic        head_empty_i,
  output logic        head_pop_o,
  output out_item_t   out_item_o,
  output logic        empty_o,
  input  logic        pop_i
);

  logic [1:0] idx_q, idx_d;
  logic       take;
  logic       at_last;

  assign empty_o    = head_empty_i;
  assign out_item_o = head_i.slots[idx_q];
  assign take       = pop_i && !head_empty_i;
  assign at_last    = ((idx_q + 2'd1) == head_i.count);
  assign head_pop_o = take && at_last;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ src/expression_lexer_top.sv @@
// expression_lexer_top: streaming lexer for integer expressions
//
// input queue side: drive in_item_i and raise push_i; the item is taken at a
// clock edge where push_i is high and full_o is low. an item carries at most
// one source byte and an optional end-of-source mark.
// result queue side: while empty_o is low, out_item_o shows the oldest token;
// raise pop_i to take it. tokens caused by one item come out in order, the
// last of them with last_of_run set.
// a token shows once its bundle is registered and earlier tokens are taken.
// throughput: one item per cycle while each item gives at most one token and
// pop_i stays high; an item with more tokens holds the result side until all
// are taken. the limit is the single result port draining a two-entry queue of
// token bundles between the classifying front end and the output serializer.
// reset: lexer idle, byte position zero, bundle queue empty, full_o low.
// when the receiver stalls, the bundle queue fills and full_o rises; no token
// is lost and the lexer state stays frozen until room frees up.
module expression_lexer_top import exl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  in_item_t  in_item_i,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  res_bundle_t fr_bundle;
  logic        fr_valid;
  logic        accept;
  res_bundle_t q_head;
  logic        q_empty;
  logic        q_pop;

  assign accept = push_i && !full_o;

  exl_front #(
    .PositionBits(POSITION_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (in_item_i),
    .bundle_o      (fr_bundle),
    .bundle_valid_o(fr_valid)
  );

  exl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && fr_valid),
    .data_i (fr_bundle),
    .full_o (full_o),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_head)
  );

  exl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .head_empty_i(q_empty),
    .head_pop_o  (q_pop),
    .out_item_o  (out_item_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i)
  );

  a_bundle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fr_valid) |-> (fr_bundle.count == 2'd1 || fr_bundle.count == 2'd2 ||
                              fr_bundle.count == 2'd3))
    else $error("bundle with bad token count");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_item_o.token_kind == TK_EOF) |-> out_item_o.last_of_run)
    else $error("eof token not last of its run");

  a_literal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_item_o.token_kind != TK_INT) |-> (out_item_o.literal_value == '0))
    else $error("non-literal token with nonzero value");

  a_eof_pops_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && out_item_o.token_kind == TK_EOF) |-> q_pop)
    else $error("eof taken without retiring its bundle");

endmodule

@@ sim/expression_lexer_top_tb.sv @@
`timescale 1ns / 1ps

module expression_lexer_top_tb;
  import exl_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandItems  = 500;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push_i = 1'b0;
  logic      full_o;
  in_item_t  in_item_i = '0;
  logic      empty_o;
  logic      pop_i = 1'b0;
  out_item_t out_item_o;

  expression_lexer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lexer shadow state
  lex_phase_e  lx_phase = PH_IDLE;
  held_op_e    lx_hop   = HOP_EQUAL;
  logic [63:0] lx_acc   = '0;
  logic [31:0] lx_start = '0;
  logic [31:0] lx_pos   = '0;

  out_item_t pending_tokens[$];

  int unsigned err_count   = 0;
  int unsigned items_sent  = 0;
  int unsigned tok_checked = 0;
  int unsigned stall_count = 0;
  int unsigned kind_hits[18];
  int unsigned cycle_count = 0;
  int unsigned hold_len    = 0;
  int unsigned hold_left   = 0;
  bit          quiet       = 1'b0;

  string name_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string name_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string punct     = "+-*/%(),=!<>";

  function automatic in_item_t mk_item(logic [7:0] c, logic present, logic eos);
    in_item_t it;
    it.data_byte     = c;
    it.byte_present  = present;
    it.end_of_source = eos;
    return it;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic bit is_head(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CharUnderscore;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CharZero + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic add_token(token_kind_e k, logic [63:0] v, logic [31:0] s, logic [31:0] n);
    out_item_t t;
    t.token_kind     = k;
    t.literal_value  = v;
    t.start_position = s;
    t.name_length    = n;
    t.last_of_run    = 1'b0;
    pending_tokens.push_back(t);
    kind_hits[k]++;
  endtask

  task automatic flush_pending();
    case (lx_phase)
      PH_NUM:   add_token(TK_INT, lx_acc, lx_start, '0);
      PH_IDENT: add_token(TK_IDENT, '0, lx_start, lx_pos - lx_start);
      PH_HELD: begin
        if (lx_hop == HOP_LESS) add_token(TK_LT, '0, lx_start, '0);
        else if (lx_hop == HOP_GREATER) add_token(TK_GT, '0, lx_start, '0);
        else add_token(TK_INVALID, '0, lx_start, '0);
      end
      default: ;
    endcase
    lx_phase = PH_IDLE;
  endtask

  task automatic begin_token(logic [7:0] c, logic [31:0] p);
    token_kind_e k;
    if (c == CharSpace || c == CharTab || c == CharCr || c == CharLf) return;
    if (is_dec(c)) begin
      lx_phase = PH_NUM;
      lx_acc   = {56'd0, c - CharZero};
      lx_start = p;
    end else if (is_head(c)) begin
      lx_phase = PH_IDENT;
      lx_start = p;
    end else if (c == CharEqual || c == CharBang || c == CharLess || c == CharGreater) begin
      lx_phase = PH_HELD;
      lx_start = p;
      if (c == CharEqual) lx_hop = HOP_EQUAL;
      else if (c == CharBang) lx_hop = HOP_BANG;
      else if (c == CharLess) lx_hop = HOP_LESS;
      else lx_hop = HOP_GREATER;
    end else begin
      case (c)
        CharPlus:    k = TK_PLUS;
        CharMinus:   k = TK_MINUS;
        CharStar:    k = TK_MUL;
        CharSlash:   k = TK_DIV;
        CharPercent: k = TK_MOD;
        CharLParen:  k = TK_LPAREN;
        CharRParen:  k = TK_RPAREN;
        CharComma:   k = TK_COMMA;
        default:     k = TK_INVALID;
      endcase
      add_token(k, '0, p, '0);
    end
  endtask

  task automatic take_byte(logic [7:0] c);
    logic [31:0] p;
    bit used;
    p = lx_pos;
    used = 1'b0;
    case (lx_phase)
      PH_NUM: begin
        if (is_dec(c)) begin
          lx_acc = lx_acc * 64'd10 + {56'd0, c - CharZero};
          used = 1'b1;
        end else if (is_head(c)) begin
          add_token(TK_INVALID, '0, lx_start, '0);
          lx_phase = PH_IDLE;
        end else begin
          flush_pending();
        end
      end
      PH_IDENT: begin
        if (is_head(c) || is_dec(c)) used = 1'b1;
        else flush_pending();
      end
      PH_HELD: begin
        if (c == CharEqual) begin
          case (lx_hop)
            HOP_EQUAL: add_token(TK_EQ, '0, lx_start, '0);
            HOP_BANG:  add_token(TK_NEQ, '0, lx_start, '0);
            HOP_LESS:  add_token(TK_LTE, '0, lx_start, '0);
            default:   add_token(TK_GTE, '0, lx_start, '0);
          endcase
          lx_phase = PH_IDLE;
          used = 1'b1;
        end else begin
          flush_pending();
        end
      end
      default: ;
    endcase
    if (!used) begin_token(c, p);
    if (lx_pos != '1) lx_pos++;
  endtask

  task automatic lex_item(in_item_t it);
    int unsigned first;
    out_item_t t;
    first = pending_tokens.size();
    if (it.byte_present) take_byte(it.data_byte);
    if (it.end_of_source) begin
      flush_pending();
      add_token(TK_EOF, '0, lx_pos, '0);
      lx_phase = PH_IDLE;
      lx_hop   = HOP_EQUAL;
      lx_acc   = '0;
      lx_start = '0;
      lx_pos   = '0;
    end
    if (pending_tokens.size() > first) begin
      t = pending_tokens.pop_back();
      t.last_of_run = 1'b1;
      pending_tokens.push_back(t);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: token %0d %s expected %0d actual %0d", $realtime, tok_checked, name,
               want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor_p
    out_item_t want;
    if (rst_ni) begin
      if (push_i && full_o) stall_count++;
      if (push_i && !full_o) lex_item(in_item_i);
      if (pop_i && !empty_o) begin
        if (pending_tokens.size() == 0) begin
          err_count++;
          $display("%0t: unexpected token expected none actual kind %0d", $realtime,
                   out_item_o.token_kind);
        end else begin
          want = pending_tokens.pop_front();
          check_field("kind", want.token_kind, out_item_o.token_kind);
          check_field("literal", want.literal_value, out_item_o.literal_value);
          check_field("start", want.start_position, out_item_o.start_position);
          check_field("length", want.name_length, out_item_o.name_length);
          check_field("last", want.last_of_run, out_item_o.last_of_run);
        end
        tok_checked++;
      end
    end
  end

  // receiver, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left != 0) begin
      pop_i <= 1'b0;
      hold_left--;
    end else begin
      pop_i <= quiet || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(in_item_t it);
    while (!quiet && $urandom_range(99) < 13) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    if (it.byte_present || it.end_of_source) items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(mk_item(s[i], 1'b1, 1'b0));
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_source();
    int n;
    int r;
    int len;
    logic [7:0] c;
    n = $urandom_range(1, 10);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 30) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 4);
        repeat (len) send_item(mk_item(rand_digit(), 1'b1, 1'b0));
      end else if (r < 50) begin
        send_item(mk_item(name_head[$urandom_range(name_head.len() - 1)], 1'b1, 1'b0));
        repeat ($urandom_range(5))
          send_item(mk_item(name_tail[$urandom_range(name_tail.len() - 1)], 1'b1, 1'b0));
      end else if (r < 70) begin
        send_item(mk_item(punct[$urandom_range(punct.len() - 1)], 1'b1, 1'b0));
        if ($urandom_range(2) == 0) send_item(mk_item(CharEqual, 1'b1, 1'b0));
      end else if (r < 85) begin
        case ($urandom_range(3))
          0: c = CharSpace;
          1: c = CharTab;
          2: c = CharCr;
          default: c = CharLf;
        endcase
        send_item(mk_item(c, 1'b1, 1'b0));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 3)) send_item(mk_item(rand_digit(), 1'b1, 1'b0));
        send_item(mk_item(name_head[$urandom_range(name_head.len() - 1)], 1'b1, 1'b0));
      end else if (r < 96) begin
        send_item(mk_item($urandom_range(1) ? CharEqual : CharBang, 1'b1, 1'b0));
      end else begin
        send_item(mk_item(rand_byte(), 1'b1, 1'b0));
      end
      if ($urandom_range(19) == 0) send_item(mk_item(rand_byte(), 1'b0, 1'b0));
    end
    if ($urandom_range(1))
      send_item(mk_item(name_tail[$urandom_range(name_tail.len() - 1)], 1'b1, 1'b1));
    else
      send_item(mk_item(rand_byte(), 1'b0, 1'b1));
  endtask

  task automatic test_directed();
    // digits then letter, lone bang, pair operators, lt flushed by a held gt
    send_text("12a==!x<>=<=!=");
    send_text("+-*/%(),");
    send_item(mk_item(8'hff, 1'b1, 1'b0));
    send_item(mk_item(8'h00, 1'b1, 1'b0));
    // lone equal, ident, then end in the same item
    send_text("=");
    send_item(mk_item("x", 1'b1, 1'b1));
    send_item(mk_item(8'ha5, 1'b0, 1'b1));
    send_item(mk_item(8'h5a, 1'b0, 1'b0));
  endtask

  task automatic test_backpressure();
    hold_len = 120;
    repeat (30) send_item(mk_item(punct[$urandom_range(7)], 1'b1, 1'b0));
    send_item(mk_item(8'h00, 1'b0, 1'b1));
  endtask

  task automatic test_pause();
    send_text("alpha+42");
    wait_drained();
    send_item(mk_item(CharSpace, 1'b1, 1'b1));
  endtask

  task automatic test_random();
    int unsigned base;
    base = items_sent;
    while (items_sent < base + RandItems) begin
      quiet = (items_sent >= base + 150) && (items_sent < base + 280);
      send_source();
    end
    quiet = 1'b0;
  endtask

  initial begin : main_p
    int unsigned kinds;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_pause();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      err_count++;
      $display("%0t: tokens left expected 0 actual %0d", $realtime, pending_tokens.size());
    end
    kinds = 0;
    foreach (kind_hits[i]) if (kind_hits[i] != 0) kinds++;
    $display("sent %0d items, checked %0d tokens covering %0d of 18 kinds", items_sent,
             tok_checked, kinds);
    $display("input side stalled on full for %0d cycles", stall_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
